### src/adnd_pkg.sv
// Shared widths, constants, tables and types of the ADPCM nibble decoder.
package adnd_pkg;

   localparam int DataW   = 8;
   localparam int CodeW   = 4;
   localparam int PredW   = 12;
   localparam int IndexW  = 6;
   localparam int StepW   = 11;
   localparam int SampleW = 16;
   localparam int VolW    = 8;
   localparam int CsrIdxW = 1;
   localparam int RspDataW = 32;

   localparam logic signed [PredW-1:0] PredMax   = 12'sd2047;
   localparam logic signed [PredW-1:0] PredMin   = -12'sd2048;
   localparam logic signed [PredW-1:0] PredReset = -12'sd2;
   localparam logic [IndexW-1:0]       IndexMax  = 6'd48;
   localparam logic [VolW-1:0]         VolumeReset = 8'd255;

   // Configuration register indexes
   localparam logic [CsrIdxW-1:0] CsrVolume = 1'b0;
   localparam logic [CsrIdxW-1:0] CsrNarrow = 1'b1;

   typedef struct packed {
      logic signed [PredW-1:0] pred;
      logic [IndexW-1:0]       index;
   } dec_state_type;

   // Step size table: floor(16 * 1.1^i)
   function automatic logic [StepW-1:0] step_size(input logic [IndexW-1:0] idx);
      logic [StepW-1:0] s;
      unique case (idx)
         6'd0:  s = 11'd16;   6'd1:  s = 11'd17;   6'd2:  s = 11'd19;
         6'd3:  s = 11'd21;   6'd4:  s = 11'd23;   6'd5:  s = 11'd25;
         6'd6:  s = 11'd28;   6'd7:  s = 11'd31;   6'd8:  s = 11'd34;
         6'd9:  s = 11'd37;   6'd10: s = 11'd41;   6'd11: s = 11'd45;
         6'd12: s = 11'd50;   6'd13: s = 11'd55;   6'd14: s = 11'd60;
         6'd15: s = 11'd66;   6'd16: s = 11'd73;   6'd17: s = 11'd80;
         6'd18: s = 11'd88;   6'd19: s = 11'd97;   6'd20: s = 11'd107;
         6'd21: s = 11'd118;  6'd22: s = 11'd130;  6'd23: s = 11'd143;
         6'd24: s = 11'd157;  6'd25: s = 11'd173;  6'd26: s = 11'd190;
         6'd27: s = 11'd209;  6'd28: s = 11'd230;  6'd29: s = 11'd253;
         6'd30: s = 11'd279;  6'd31: s = 11'd307;  6'd32: s = 11'd337;
         6'd33: s = 11'd371;  6'd34: s = 11'd408;  6'd35: s = 11'd449;
         6'd36: s = 11'd494;  6'd37: s = 11'd544;  6'd38: s = 11'd598;
         6'd39: s = 11'd658;  6'd40: s = 11'd724;  6'd41: s = 11'd796;
         6'd42: s = 11'd876;  6'd43: s = 11'd963;  6'd44: s = 11'd1060;
         6'd45: s = 11'd1166; 6'd46: s = 11'd1282; 6'd47: s = 11'd1411;
         default: s = 11'd1552;
      endcase
      return s;
   endfunction

   // Step index movement by the low three code bits
   function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
      logic signed [4:0] a;
      unique case (mag)
         3'd4:    a = 5'sd2;
         3'd5:    a = 5'sd4;
         3'd6:    a = 5'sd6;
         3'd7:    a = 5'sd8;
         default: a = -5'sd1;
      endcase
      return a;
   endfunction

endpackage

### src/adnd_decode.sv
// One nibble decode step: step lookup, difference, predictor and index update.
module adnd_decode (
   input  adnd_pkg::dec_state_type          cur_i,
   input  logic [adnd_pkg::CodeW-1:0]       code_i,
   output adnd_pkg::dec_state_type          next_o
);

   logic [adnd_pkg::StepW-1:0]  step_w;
   logic [11:0]                 diff_mag_w;
   logic signed [13:0]          diff_w;
   logic signed [13:0]          sum_w;
   logic signed [4:0]           adj_w;
   logic signed [6:0]           idx_sum_w;

   always_comb begin
      step_w = adnd_pkg::step_size(cur_i.index);
      diff_mag_w = 12'(step_w >> 3)
                 + (code_i[2] ? 12'(step_w)      : 12'd0)
                 + (code_i[1] ? 12'(step_w >> 1) : 12'd0)
                 + (code_i[0] ? 12'(step_w >> 2) : 12'd0);
      diff_w = code_i[3] ? -$signed({2'b00, diff_mag_w}) : $signed({2'b00, diff_mag_w});
      sum_w  = $signed({{2{cur_i.pred[adnd_pkg::PredW-1]}}, cur_i.pred}) + diff_w;

      // saturate the predictor
      if (sum_w > 14'(adnd_pkg::PredMax)) begin
         next_o.pred = adnd_pkg::PredMax;
      end else if (sum_w < 14'(adnd_pkg::PredMin)) begin
         next_o.pred = adnd_pkg::PredMin;
      end else begin
         next_o.pred = sum_w[adnd_pkg::PredW-1:0];
      end

      adj_w     = adnd_pkg::index_adjust(code_i[2:0]);
      idx_sum_w = $signed({1'b0, cur_i.index}) + $signed({{2{adj_w[4]}}, adj_w});
      if (idx_sum_w < 7'sd0) begin
         next_o.index = '0;
      end else if (idx_sum_w > $signed({1'b0, adnd_pkg::IndexMax})) begin
         next_o.index = adnd_pkg::IndexMax;
      end else begin
         next_o.index = idx_sum_w[adnd_pkg::IndexW-1:0];
      end
   end

endmodule

### src/adnd_scale.sv
// Output gain: predictor times volume, divided by 16 or 4096 toward zero.
module adnd_scale (
   input  logic signed [adnd_pkg::PredW-1:0]   pred_i,
   input  logic [adnd_pkg::VolW-1:0]           volume_i,
   input  logic                                narrow_i,
   output logic signed [adnd_pkg::SampleW-1:0] sample_o
);

   logic signed [20:0] prod_w;
   logic signed [20:0] biased_w;
   logic signed [20:0] shifted_w;

   always_comb begin
      prod_w = 21'(pred_i) * 21'($signed({1'b0, volume_i}));
      // bias negatives so the arithmetic shift truncates toward zero
      if (prod_w[20]) begin
         biased_w = prod_w + (narrow_i ? 21'sd4095 : 21'sd15);
      end else begin
         biased_w = prod_w;
      end
      shifted_w = narrow_i ? (biased_w >>> 12) : (biased_w >>> 4);
      sample_o  = shifted_w[adnd_pkg::SampleW-1:0];
   end

endmodule

### src/adpcm_nibble_decoder.sv
// Top level of the 4-bit ADPCM to 16-bit PCM nibble decoder.
// Each accepted byte yields two results, high nibble first (tlast low) and then the
// low nibble (tlast high). When the result side keeps up, the predictor and step
// index loop in the decode stage handles one nibble a cycle, and a new byte is
// accepted as the low nibble of the current one is decoded. The high-nibble result
// passes from the byte register through the decode stage and the scale stage into
// the output register; the low-nibble result follows it on the same path.
// The restart flag sets predictor to -2 and step index to 0 before the high nibble.
// Configuration: index 0 volume (8 bits), index 1 narrow output (bit 0); write only
// while no item is in flight.
module adpcm_nibble_decoder (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [adnd_pkg::DataW-1:0]        req_tdata,   // [7:0] data_byte
   input  logic                              req_tuser,   // [0] restart
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [adnd_pkg::RspDataW-1:0]     rsp_tdata,   // [15:0] pcm_sample,
                                                          // [27:16] raw_predictor, zero pad
   output logic                              rsp_tlast,   // last_nibble
   // configuration
   input  logic                              csr_we,
   input  logic [adnd_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [adnd_pkg::VolW-1:0]         csr_wdata
);

   // configuration registers
   logic [adnd_pkg::VolW-1:0] volume_ff, volume_in;
   logic                      narrow_ff, narrow_in;

   // byte holding stage
   logic [adnd_pkg::DataW-1:0] byte_ff, byte_in;
   logic                       restart_ff, restart_in;
   logic                       busy_ff, busy_in;
   logic                       phase_ff, phase_in;   // 0: high nibble, 1: low nibble

   // decoder state
   adnd_pkg::dec_state_type state_ff, state_in;

   // decode-to-scale stage
   logic signed [adnd_pkg::PredW-1:0] mid_pred_ff, mid_pred_in;
   logic                              mid_last_ff, mid_last_in;
   logic                              mid_valid_ff, mid_valid_in;

   // output register
   logic signed [adnd_pkg::SampleW-1:0] out_sample_ff, out_sample_in;
   logic signed [adnd_pkg::PredW-1:0]   out_pred_ff, out_pred_in;
   logic                                out_last_ff, out_last_in;
   logic                                out_valid_ff, out_valid_in;

   logic                              out_ready_w;
   logic                              scale_fire_w;
   logic                              mid_ready_w;
   logic                              dec_fire_w;
   logic                              req_fire_w;
   logic [adnd_pkg::CodeW-1:0]        code_w;
   adnd_pkg::dec_state_type           dec_cur_w;
   adnd_pkg::dec_state_type           dec_next_w;
   logic signed [adnd_pkg::SampleW-1:0] sample_w;

   // handshake chain: each stage advances when the one after it has room
   assign out_ready_w  = !out_valid_ff || rsp_tready;
   assign scale_fire_w = mid_valid_ff && out_ready_w;
   assign mid_ready_w  = !mid_valid_ff || scale_fire_w;
   assign dec_fire_w   = busy_ff && mid_ready_w;
   // take the next byte as soon as the low nibble of the current one leaves
   assign req_tready   = !busy_ff || (dec_fire_w && phase_ff);
   assign req_fire_w   = req_tvalid && req_tready;

   // pick the nibble and apply restart ahead of the high nibble
   always_comb begin
      code_w = phase_ff ? byte_ff[3:0] : byte_ff[7:4];
      if (!phase_ff && restart_ff) begin
         dec_cur_w.pred  = adnd_pkg::PredReset;
         dec_cur_w.index = '0;
      end else begin
         dec_cur_w = state_ff;
      end
   end

   adnd_decode u_decode (
      .cur_i  (dec_cur_w),
      .code_i (code_w),
      .next_o (dec_next_w)
   );

   adnd_scale u_scale (
      .pred_i   (mid_pred_ff),
      .volume_i (volume_ff),
      .narrow_i (narrow_ff),
      .sample_o (sample_w)
   );

   always_comb begin
      volume_in = volume_ff;
      narrow_in = narrow_ff;
      if (csr_we) begin
         unique case (csr_index)
            adnd_pkg::CsrVolume: volume_in = csr_wdata;
            adnd_pkg::CsrNarrow: narrow_in = csr_wdata[0];
            default: ;
         endcase
      end

      // byte stage: load on accept, otherwise step through the two nibbles
      byte_in    = byte_ff;
      restart_in = restart_ff;
      busy_in    = busy_ff;
      phase_in   = phase_ff;
      if (req_fire_w) begin
         byte_in    = req_tdata;
         restart_in = req_tuser;
         busy_in    = 1'b1;
         phase_in   = 1'b0;
      end else if (dec_fire_w) begin
         if (phase_ff) begin
            busy_in = 1'b0;
         end else begin
            phase_in = 1'b1;
         end
      end

      // advance the decoder state once per nibble
      state_in     = dec_fire_w ? dec_next_w : state_ff;
      mid_pred_in  = dec_fire_w ? dec_next_w.pred : mid_pred_ff;
      mid_last_in  = dec_fire_w ? phase_ff : mid_last_ff;
      mid_valid_in = dec_fire_w ? 1'b1 : (scale_fire_w ? 1'b0 : mid_valid_ff);

      // output register: hold while stalled
      out_sample_in = scale_fire_w ? sample_w : out_sample_ff;
      out_pred_in   = scale_fire_w ? mid_pred_ff : out_pred_ff;
      out_last_in   = scale_fire_w ? mid_last_ff : out_last_ff;
      out_valid_in  = scale_fire_w ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff       <= adnd_pkg::VolumeReset;
         narrow_ff       <= 1'b0;
         busy_ff         <= 1'b0;
         phase_ff        <= 1'b0;
         state_ff.pred   <= adnd_pkg::PredReset;
         state_ff.index  <= '0;
         mid_valid_ff    <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         volume_ff    <= volume_in;
         narrow_ff    <= narrow_in;
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         state_ff     <= state_in;
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      restart_ff    <= restart_in;
      mid_pred_ff   <= mid_pred_in;
      mid_last_ff   <= mid_last_in;
      out_sample_ff <= out_sample_in;
      out_pred_ff   <= out_pred_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_pred_ff, out_sample_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

### src/adnd_checker.sv
// Port-level checks for the ADPCM nibble decoder, bound to the top level.
module adnd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [adnd_pkg::RspDataW-1:0]     rsp_tdata,
   input logic                              rsp_tlast
);

   // results alternate high nibble then low nibble
   logic expect_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_last_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         expect_last_ff <= !expect_last_ff;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_nibble_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == expect_last_ff)
      else $error("nibble results out of order");

   a_sign_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15] |-> rsp_tdata[27])
      else $error("negative sample from non-negative predictor");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

endmodule

bind adpcm_nibble_decoder adnd_checker u_adnd_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for the ADPCM nibble decoder: directed table, random runs, scoreboard.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Cycles with no item moving on either channel before the run is abandoned
   localparam int StallLimit = 3000;
   // Receiver hold-off used once to back the block up into its input
   localparam int LongHold = 200;
   localparam int ItemsPerPhase = 330;
   localparam int NumPhases = 6;

   // floor(16 * 1.1^i), one entry per step index
   localparam int StepTable [0:48] = '{
      16, 17, 19, 21, 23, 25, 28, 31, 34, 37,
      41, 45, 50, 55, 60, 66, 73, 80, 88, 97,
      107, 118, 130, 143, 157, 173, 190, 209, 230, 253,
      279, 307, 337, 371, 408, 449, 494, 544, 598, 658,
      724, 796, 876, 963, 1060, 1166, 1282, 1411, 1552
   };

   // One decoded nibble as it leaves the block
   typedef struct packed {
      logic signed [adnd_pkg::SampleW-1:0] sample;
      logic signed [adnd_pkg::PredW-1:0]   pred;
      logic                                last;
   } nibble_type;

   // Directed stimulus row; typed rows carry their results written out by hand
   typedef struct packed {
      logic [adnd_pkg::DataW-1:0]          data;
      logic                                restart;
      logic                                typed;
      logic signed [adnd_pkg::SampleW-1:0] hi_sample;
      logic signed [adnd_pkg::PredW-1:0]   hi_pred;
      logic signed [adnd_pkg::SampleW-1:0] lo_sample;
      logic signed [adnd_pkg::PredW-1:0]   lo_pred;
   } dir_row_type;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [adnd_pkg::DataW-1:0]    req_tdata = '0;
   logic                          req_tuser = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [adnd_pkg::RspDataW-1:0] rsp_tdata;
   logic                          rsp_tlast;
   logic                          csr_we = 1'b0;
   logic [adnd_pkg::CsrIdxW-1:0]  csr_index = '0;
   logic [adnd_pkg::VolW-1:0]     csr_wdata = '0;

   // Decoder state and settings as the block should hold them
   int      dec_pred = -2;
   int      dec_index = 0;
   int      gain = 255;
   bit      narrow_mode = 1'b0;

   nibble_type pending_nibbles [$];
   int      errors = 0;
   int      quiet_cycles = 0;
   bit      steady = 1'b0;            // both sides run without gaps while set
   bit      long_hold_pending = 1'b0;

   // Start from reset state, then walk to both predictor rails and back.
   // Every code value 0..15 appears at least once.
   dir_row_type directed_rows [24] = '{
      '{8'h00, 1'b0, 1'b1,   0,   0,   31,  2},   // first bytes after reset
      '{8'h77, 1'b1, 1'b1, 446,  28, 1450, 91},   // restart, largest positive codes
      '{8'h77, 1'b0, 1'b0,   0,   0,    0,  0},
      '{8'h77, 1'b0, 1'b0,   0,   0,    0,  0},
      '{8'h77, 1'b0, 1'b0,   0,   0,    0,  0},   // predictor pinned at +2047
      '{8'h77, 1'b0, 1'b0,   0,   0,    0,  0},   // step index pinned at 48
      '{8'h77, 1'b0, 1'b0,   0,   0,    0,  0},
      '{8'h77, 1'b0, 1'b0,   0,   0,    0,  0},
      '{8'hFF, 1'b0, 1'b0,   0,   0,    0,  0},   // swing down to -2048
      '{8'hFF, 1'b0, 1'b0,   0,   0,    0,  0},
      '{8'hFF, 1'b0, 1'b0,   0,   0,    0,  0},
      '{8'hFF, 1'b0, 1'b0,   0,   0,    0,  0},
      '{8'h88, 1'b1, 1'b1, -63,  -4,  -95, -6},   // restart, smallest negative codes
      '{8'h0F, 1'b0, 1'b0,   0,   0,    0,  0},
      '{8'hF0, 1'b0, 1'b0,   0,   0,    0,  0},
      '{8'h5A, 1'b0, 1'b0,   0,   0,    0,  0},
      '{8'hA5, 1'b0, 1'b0,   0,   0,    0,  0},
      '{8'h34, 1'b0, 1'b0,   0,   0,    0,  0},
      '{8'hC3, 1'b0, 1'b0,   0,   0,    0,  0},
      '{8'h69, 1'b1, 1'b0,   0,   0,    0,  0},
      '{8'h96, 1'b0, 1'b0,   0,   0,    0,  0},
      '{8'h12, 1'b0, 1'b0,   0,   0,    0,  0},
      '{8'hDE, 1'b0, 1'b0,   0,   0,    0,  0},
      '{8'hB1, 1'b0, 1'b0,   0,   0,    0,  0}
   };

   adpcm_nibble_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Decode one code: step lookup, difference, saturating predictor and index, then scale
   function automatic nibble_type decode_code(input logic [adnd_pkg::CodeW-1:0] code,
                                              input logic last);
      int         step;
      int         diff;
      int         prod;
      int         scaled;
      nibble_type r;
      step = StepTable[dec_index];
      diff = step / 8;
      if (code[2]) diff += step;
      if (code[1]) diff += step / 2;
      if (code[0]) diff += step / 4;
      if (code[3]) diff = -diff;
      dec_pred += diff;
      if (dec_pred > int'(adnd_pkg::PredMax)) dec_pred = int'(adnd_pkg::PredMax);
      else if (dec_pred < int'(adnd_pkg::PredMin)) dec_pred = int'(adnd_pkg::PredMin);
      // small magnitudes back off by one, large ones jump by 2, 4, 6 or 8
      dec_index += code[2] ? 2 * (int'(code[1:0]) + 1) : -1;
      if (dec_index > int'(adnd_pkg::IndexMax)) dec_index = int'(adnd_pkg::IndexMax);
      else if (dec_index < 0) dec_index = 0;
      prod = dec_pred * gain;
      scaled = narrow_mode ? prod / 4096 : prod / 16;
      r.sample = adnd_pkg::SampleW'(scaled);
      r.pred = adnd_pkg::PredW'(dec_pred);
      r.last = last;
      return r;
   endfunction

   // High nibble first; a restart clears the state before it
   function automatic void decode_byte(input logic [adnd_pkg::DataW-1:0] b, input logic rst,
                                       output nibble_type hi, output nibble_type lo);
      if (rst) begin
         dec_pred = int'(adnd_pkg::PredReset);
         dec_index = 0;
      end
      hi = decode_code(b[7:4], 1'b0);
      lo = decode_code(b[3:0], 1'b1);
   endfunction

   // Random byte shaped by run kind: loud runs ride the rails, quiet runs stay small
   function automatic logic [adnd_pkg::DataW-1:0] make_byte(input int kind);
      logic s;
      logic [adnd_pkg::CodeW-1:0] h;
      logic [adnd_pkg::CodeW-1:0] l;
      s = 1'($urandom);
      case (kind)
         6, 7: begin
            h = {s, 1'b1, 2'($urandom)};
            l = {s, 1'b1, 2'($urandom)};
         end
         8: begin
            h = {1'($urandom), 1'b0, 2'($urandom)};
            l = {1'($urandom), 1'b0, 2'($urandom)};
         end
         default: begin
            h = 4'($urandom);
            l = 4'($urandom);
         end
      endcase
      return {h, l};
   endfunction

   // Offer one byte after a random gap; leave tvalid high so back-to-back items need no toggle
   task automatic offer_byte(input logic [adnd_pkg::DataW-1:0] b, input logic rst);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= rst;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop the request, drain every result, then let the pipeline empty out
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_nibbles.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write both registers back to back; the narrow word carries junk above bit 0
   task automatic write_regs(input logic [adnd_pkg::VolW-1:0] vol,
                             input logic [adnd_pkg::VolW-1:0] narrow_word);
      csr_we    <= 1'b1;
      csr_index <= adnd_pkg::CsrVolume;
      csr_wdata <= vol;
      @(posedge clock);
      gain = int'(vol);
      csr_index <= adnd_pkg::CsrNarrow;
      csr_wdata <= narrow_word;
      @(posedge clock);
      narrow_mode = narrow_word[0];
      csr_we <= 1'b0;
   endtask

   // Random part: runs of one kind with random content, some of them gapless
   task automatic run_random(input int count);
      int                         kind;
      int                         len;
      int                         k;
      logic [adnd_pkg::DataW-1:0] b;
      logic                       rst;
      nibble_type                 hi;
      nibble_type                 lo;
      while (count > 0) begin
         kind = $urandom_range(0, 9);
         len = $urandom_range(2, 16);
         steady = ($urandom_range(0, 4) == 0);
         for (k = 0; k < len && count > 0; k++) begin
            b = make_byte(kind);
            rst = (k == 0 && kind == 9) || ($urandom_range(0, 47) == 0);
            offer_byte(b, rst);
            decode_byte(b, rst, hi, lo);
            pending_nibbles.push_back(hi);
            pending_nibbles.push_back(lo);
            count--;
         end
      end
      steady = 1'b0;
   endtask

   // Stimulus and phase control
   initial begin
      nibble_type hi;
      nibble_type lo;
      int         p;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table at reset settings; hand-written rows take their own results
      foreach (directed_rows[i]) begin
         offer_byte(directed_rows[i].data, directed_rows[i].restart);
         decode_byte(directed_rows[i].data, directed_rows[i].restart, hi, lo);
         if (directed_rows[i].typed) begin
            hi.sample = directed_rows[i].hi_sample;
            hi.pred   = directed_rows[i].hi_pred;
            lo.sample = directed_rows[i].lo_sample;
            lo.pred   = directed_rows[i].lo_pred;
         end
         pending_nibbles.push_back(hi);
         pending_nibbles.push_back(lo);
      end

      // Walk the settings: silence, full gain narrow, unit gain with masked junk, half gain narrow, then random
      for (p = 0; p < NumPhases; p++) begin
         settle();
         case (p)
            0: write_regs(8'd0, 8'h00);
            1: write_regs(8'd255, 8'h01);
            2: write_regs(8'd1, 8'hFE);
            3: write_regs(8'd128, 8'hFF);
            default: write_regs(8'($urandom), 8'($urandom));
         endcase
         // back the block up once while the sender keeps offering
         if (p == 1) long_hold_pending = 1'b1;
         run_random(ItemsPerPhase);
      end

      settle();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Result side: random stalls per item, one long hold-off on request
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 4);
         if (long_hold_pending) begin
            stall = LongHold;
            long_hold_pending = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Compare each accepted result with the oldest expectation, field by field
   always @(posedge clock) begin
      nibble_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_nibbles.size() == 0) begin
            $error("unexpected result: pcm_sample %0d raw_predictor %0d last_nibble %0b",
                   $signed(rsp_tdata[15:0]), $signed(rsp_tdata[27:16]), rsp_tlast);
            errors++;
         end else begin
            want = pending_nibbles.pop_front();
            if (rsp_tdata[15:0] !== want.sample) begin
               $error("pcm_sample: expected %0d, got %0d",
                      want.sample, $signed(rsp_tdata[15:0]));
               errors++;
            end
            if (rsp_tdata[27:16] !== want.pred) begin
               $error("raw_predictor: expected %0d, got %0d",
                      want.pred, $signed(rsp_tdata[27:16]));
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_nibble: expected %0b, got %0b", want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // Watchdog: abandon the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
